// File: hw/rtl/fw_pkg.sv
// Shared constants, types and control bundles for the Fenwick range-sum block.
`default_nettype none

package fw_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int VALUE_BITS   = 32;
  localparam int IDX_BITS     = $clog2(MAX_ELEMENTS);
  localparam int LEN_BITS     = 11;
  // a tree node may step one power of two past the top while walking upward
  localparam int NODE_BITS    = IDX_BITS + 2;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [LEN_BITS-1:0]   len_t;
  typedef logic [NODE_BITS-1:0]  node_t;

  localparam len_t LEN_RESET = len_t'(MAX_ELEMENTS);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SET   = 2'd1,
    OP_RANGE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ELEM_RD,
    ST_ELEM_WB,
    ST_UPD,
    ST_SUM_HI,
    ST_SUM_LO,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic elem_wr;
    logic upd_step;
    logic sum_step;
    logic sum_sub;
    logic load_lo;
    logic finish;
  } fw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_err;
    logic in_range;
    op_t  op;
    logic upd_end;
    logic sum_end;
  } fw_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/fw_ctrl.sv
// Controller state machine: sequences clearing, element access and tree walks.
`default_nettype none

module fw_ctrl
  import fw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire fw_stat_t stat,
  output fw_cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.in_err) state_next = ST_DRAIN;
          else if (stat.in_range) state_next = ST_SUM_HI;
          else state_next = ST_ELEM_RD;
        end
      end
      ST_ELEM_RD: state_next = ST_ELEM_WB;
      ST_ELEM_WB: begin
        cmd.elem_wr = 1'b1;
        if (stat.op == OP_READ) state_next = ST_FINISH;
        else state_next = ST_UPD;
      end
      ST_UPD: begin
        if (stat.upd_end) state_next = ST_DRAIN;
        else cmd.upd_step = 1'b1;
      end
      ST_SUM_HI: begin
        if (stat.sum_end) begin
          cmd.load_lo = 1'b1;
          state_next  = ST_SUM_LO;
        end else begin
          cmd.sum_step = 1'b1;
        end
      end
      ST_SUM_LO: begin
        if (stat.sum_end) begin
          state_next = ST_DRAIN;
        end else begin
          cmd.sum_step = 1'b1;
          cmd.sum_sub  = 1'b1;
        end
      end
      // last tree read or write lands here
      ST_DRAIN: state_next = ST_FINISH;
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/fw_dp.sv
// Datapath: length register, element and tree memories, walk node and accumulator.
`default_nettype none

module fw_dp
  import fw_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire len_t         active_length,
  input  wire logic [1:0]   opcode,
  input  wire idx_t         element_index,
  input  wire idx_t         range_low,
  input  wire idx_t         range_high,
  input  wire value_t       operand_value,
  input  wire fw_cmd_t      cmd,
  output fw_stat_t          stat,
  output value_t            result_value,
  output logic              index_error,
  output logic              result_strobe
);

  value_t elem_mem [MAX_ELEMENTS];
  value_t tree_mem [MAX_ELEMENTS];

  len_t   len_r;
  len_t   eff_len;
  len_t   n_r;
  op_t    op_r;
  idx_t   idx_r;
  idx_t   lo_r;
  value_t val_r;
  logic   err_r;
  node_t  node;
  node_t  lowbit;
  value_t delta;
  value_t acc;
  value_t res;
  value_t elem_q;
  value_t tree_q;
  value_t elem_new;
  idx_t   clr_addr;
  idx_t   tree_raddr;
  idx_t   tree_waddr_q;
  logic   pend_upd;
  logic   pend_acc;
  logic   pend_sub;
  logic   elem_we;
  idx_t   elem_waddr;
  value_t elem_wdata;
  logic   tree_we;
  idx_t   tree_waddr;
  value_t tree_wdata;
  logic   in_range;
  logic   in_err;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_r <= LEN_RESET;
    end else if (cfg_valid) begin
      len_r <= active_length;
    end
  end

  assign eff_len = (len_r > len_t'(MAX_ELEMENTS)) ? len_t'(MAX_ELEMENTS) : len_r;

  assign in_range = (op_t'(opcode) == OP_RANGE);
  assign in_err   = in_range ? (({1'b0, range_low} >= eff_len) || ({1'b0, range_high} >= eff_len))
                             : ({1'b0, element_index} >= eff_len);

  assign lowbit     = node & (~node + node_t'(1));
  assign tree_raddr = idx_t'(node - node_t'(1));

  assign elem_new = (op_r == OP_ADD) ? (elem_q + val_r) : val_r;

  assign stat.clr_last = (clr_addr == '1);
  assign stat.in_err   = in_err;
  assign stat.in_range = in_range;
  assign stat.op       = op_r;
  assign stat.upd_end  = (node == '0) || (node > {1'b0, n_r});
  assign stat.sum_end  = (node == '0);

  // request capture and walk node
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(opcode);
      idx_r <= element_index;
      lo_r  <= range_low;
      val_r <= operand_value;
      err_r <= in_err;
      n_r   <= eff_len;
      node  <= {2'b00, range_high} + node_t'(1);
    end else if (cmd.elem_wr) begin
      node <= {2'b00, idx_r} + node_t'(1);
    end else if (cmd.upd_step) begin
      node <= node + lowbit;
    end else if (cmd.sum_step) begin
      node <= node - lowbit;
    end else if (cmd.load_lo) begin
      node <= {2'b00, lo_r};
    end
    if (cmd.elem_wr) begin
      delta <= (op_r == OP_ADD) ? val_r : (val_r - elem_q);
      res   <= (op_r == OP_READ) ? elem_q : elem_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      pend_upd <= 1'b0;
      pend_acc <= 1'b0;
      pend_sub <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + idx_t'(1);
      pend_upd <= cmd.upd_step;
      pend_acc <= cmd.sum_step;
      pend_sub <= cmd.sum_sub;
    end
  end

  always_ff @(posedge clk) begin
    tree_waddr_q <= tree_raddr;
    if (cmd.load) begin
      acc <= '0;
    end else if (pend_acc) begin
      acc <= pend_sub ? (acc - tree_q) : (acc + tree_q);
    end
  end

  // element store
  assign elem_we    = cmd.clr_step || (cmd.elem_wr && (op_r != OP_READ));
  assign elem_waddr = cmd.clr_step ? clr_addr : idx_r;
  assign elem_wdata = cmd.clr_step ? '0 : elem_new;

  always_ff @(posedge clk) begin
    if (elem_we) elem_mem[elem_waddr] <= elem_wdata;
    elem_q <= elem_mem[idx_r];
  end

  // tree store: read one node per cycle, write back the previous one
  assign tree_we    = cmd.clr_step || pend_upd;
  assign tree_waddr = cmd.clr_step ? clr_addr : tree_waddr_q;
  assign tree_wdata = cmd.clr_step ? '0 : (tree_q + delta);

  always_ff @(posedge clk) begin
    if (tree_we) tree_mem[tree_waddr] <= tree_wdata;
    tree_q <= tree_mem[tree_raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result_value <= err_r ? '0 : ((op_r == OP_RANGE) ? acc : res);
      index_error  <= err_r;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fenwick_tree_range_sum.sv
// Fenwick tree range sum: top level joining controller and datapath.
// After reset both 1024-entry stores are cleared, one entry a cycle, with busy high. Results
// strobe after accept; an index error touches no store, a read only the element store, an
// add/set also the k tree nodes updated (up to 11), a range sum the p, q nodes of its two
// prefix walks (up to 10 each). One request at a time; one tree memory access per node sets
// the rate. Results show for one cycle; a new request may be taken in that same cycle.
`default_nettype none

module fenwick_tree_range_sum
  import fw_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire len_t         active_length,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   opcode,
  input  wire idx_t         element_index,
  input  wire idx_t         range_low,
  input  wire idx_t         range_high,
  input  wire logic signed [VALUE_BITS-1:0] operand_value,
  output logic              result_strobe,
  output logic signed [VALUE_BITS-1:0] result_value,
  output logic              index_error
);

  fw_cmd_t  cmd;
  fw_stat_t stat;
  value_t   res_bits;

  fw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  fw_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .active_length (active_length),
    .opcode        (opcode),
    .element_index (element_index),
    .range_low     (range_low),
    .range_high    (range_high),
    .operand_value (value_t'(operand_value)),
    .cmd           (cmd),
    .stat          (stat),
    .result_value  (res_bits),
    .index_error   (index_error),
    .result_strobe (result_strobe)
  );

  assign result_value = signed'(res_bits);

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the Fenwick tree range-sum block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fw_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 120;

  typedef struct packed {
    logic   is_cfg;
    len_t   length;
    op_t    op;
    idx_t   idx;
    idx_t   lo;
    idx_t   hi;
    value_t operand;
  } request_t;

  typedef struct packed {
    value_t value;
    logic   err;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  len_t active_length = LEN_RESET;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode = '0;
  idx_t element_index = '0;
  idx_t range_low = '0;
  idx_t range_high = '0;
  logic signed [VALUE_BITS-1:0] operand_value = '0;
  logic result_strobe;
  logic signed [VALUE_BITS-1:0] result_value;
  logic index_error;

  fenwick_tree_range_sum dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mirror of the block's table, tree and length register
  value_t elem_mirror [1:MAX_ELEMENTS];
  value_t tree_mirror [1:MAX_ELEMENTS];
  len_t   length_mirror;

  request_t stimulus[$];
  outcome_t awaited_results[$];

  logic req_taken = 1'b0;
  logic cfg_taken = 1'b0;
  logic timed_out = 1'b0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   settle_cycles = 0;

  task automatic report_mismatch(input string what, input value_t got, input value_t want);
    if (mismatches < 40)
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic value_t prefix_total(input int unsigned count);
    value_t acc;
    acc = '0;
    if (count > MAX_ELEMENTS) count = MAX_ELEMENTS;
    while (count != 0) begin
      acc += tree_mirror[count];
      count -= count & -count;
    end
    return acc;
  endfunction

  task automatic fenwick_apply(input request_t rq);
    int unsigned lim, node;
    value_t delta;
    outcome_t out;
    lim = (length_mirror > MAX_ELEMENTS) ? MAX_ELEMENTS : length_mirror;
    out = '0;
    if (rq.op == OP_RANGE) begin
      out.err = (rq.lo >= lim) || (rq.hi >= lim);
      if (!out.err)
        out.value = prefix_total(rq.hi + 1) - prefix_total(rq.lo);
    end else begin
      out.err = rq.idx >= lim;
      if (!out.err) begin
        node = rq.idx + 1;
        if (rq.op != OP_READ) begin
          // set is applied as the difference from the current value
          delta = (rq.op == OP_ADD) ? rq.operand : rq.operand - elem_mirror[node];
          elem_mirror[node] += delta;
          while (node != 0 && node <= lim) begin
            tree_mirror[node] += delta;
            node += node & -node;
          end
          node = rq.idx + 1;
        end
        out.value = elem_mirror[node];
      end
    end
    awaited_results.push_back(out);
  endtask

  task automatic add_op(input op_t op, input idx_t idx, input idx_t lo, input idx_t hi,
                        input value_t val);
    request_t rq;
    rq = '0;
    rq.op = op;
    rq.idx = idx;
    rq.lo = lo;
    rq.hi = hi;
    rq.operand = val;
    stimulus.push_back(rq);
  endtask

  task automatic add_length(input len_t len);
    request_t rq;
    rq = '0;
    rq.is_cfg = 1'b1;
    rq.length = len;
    stimulus.push_back(rq);
  endtask

  function automatic idx_t pick_index(input int unsigned lim);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (lim == 0 || pick == 0) return idx_t'($urandom);
    if (pick < 3) return idx_t'(lim - 1);
    if (pick == 3) return '0;
    return idx_t'($urandom_range(0, lim - 1));
  endfunction

  task automatic add_random_op(input int unsigned lim);
    int unsigned pick;
    value_t val;
    pick = $urandom_range(0, 9);
    if (pick < 5) val = $urandom;
    else if (pick < 8) val = value_t'($urandom_range(0, 32)) - 16;
    else if (pick == 8) val = 32'h8000_0000;
    else val = 32'h7fff_ffff;
    add_op(op_t'($urandom_range(0, 3)), pick_index(lim), pick_index(lim), pick_index(lim), val);
  endtask

  // driver: one request or one length write at a time, in bursts with gaps
  always @(negedge clk) begin
    logic drive_start, drive_cfg;
    request_t rq;
    drive_start = start && !req_taken;
    drive_cfg = cfg_valid && !cfg_taken;
    if (!rst && awaited_results.size() == 0 && !busy && !start) settle_cycles++;
    else settle_cycles = 0;
    if (rst || drive_start || drive_cfg) begin
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (stimulus.size() > 0) begin
      if (stimulus[0].is_cfg) begin
        // length changes only once the block has gone quiet
        if (settle_cycles >= 3) begin
          rq = stimulus.pop_front();
          active_length <= rq.length;
          drive_cfg = 1'b1;
        end
      end else begin
        rq = stimulus.pop_front();
        opcode <= rq.op;
        element_index <= rq.idx;
        range_low <= rq.lo;
        range_high <= rq.hi;
        operand_value <= rq.operand;
        drive_start = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    start <= drive_start;
    cfg_valid <= drive_cfg;
  end

  // monitor: check results, then predict newly accepted requests
  always @(posedge clk) begin
    outcome_t want;
    request_t rq;
    req_taken <= !rst && start && !busy;
    cfg_taken <= !rst && cfg_valid && cfg_ready;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (result_strobe) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unrequested result", result_value, '0);
        end else begin
          want = awaited_results.pop_front();
          if (result_value !== want.value)
            report_mismatch("result_value", result_value, want.value);
          if (index_error !== want.err)
            report_mismatch("index_error", value_t'(index_error), value_t'(want.err));
        end
      end
      if (cfg_valid && cfg_ready) begin
        length_mirror = active_length;
      end
      if (start && !busy) begin
        rq = '0;
        rq.op = op_t'(opcode);
        rq.idx = element_index;
        rq.lo = range_low;
        rq.hi = range_high;
        rq.operand = operand_value;
        fenwick_apply(rq);
      end
      if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) timed_out <= 1'b1;
    end
  end

  initial begin
    int unsigned len, lim;
    for (int i = 1; i <= MAX_ELEMENTS; i++) begin
      elem_mirror[i] = '0;
      tree_mirror[i] = '0;
    end
    length_mirror = LEN_RESET;

    // extremes at the reset length
    add_op(OP_READ, 0, 0, 0, '0);
    add_op(OP_READ, 1023, 1023, 1023, '0);
    add_op(OP_ADD, 0, 1023, 0, 32'h7fff_ffff);
    add_op(OP_ADD, 0, 0, 1023, 32'h0000_0001);
    add_op(OP_ADD, 1023, 0, 0, 32'h8000_0000);
    add_op(OP_SET, 512, 0, 0, 32'hffff_ffff);
    add_op(OP_SET, 1023, 0, 0, 32'h0000_0005);
    add_op(OP_RANGE, 0, 0, 1023, '0);
    add_op(OP_RANGE, 0, 1023, 1023, '0);
    add_op(OP_RANGE, 1023, 0, 0, '0);
    add_op(OP_RANGE, 0, 600, 3, '0);   // reversed range
    add_op(OP_READ, 512, 0, 0, '0);
    // zero length flags everything
    add_length(0);
    add_op(OP_ADD, 0, 0, 0, 32'h0000_0001);
    add_op(OP_RANGE, 0, 0, 0, '0);
    add_op(OP_READ, 0, 0, 0, '0);
    add_op(OP_SET, 0, 0, 0, 32'h0000_0009);
    // above the maximum acts as the maximum
    add_length(2047);
    add_op(OP_RANGE, 0, 0, 1023, '0);
    add_op(OP_ADD, 1023, 0, 0, 32'h0000_0003);
    add_op(OP_READ, 1023, 0, 0, '0);
    add_op(OP_ADD, 0, 0, 0, 32'h0000_0004);
    add_length(1);
    add_op(OP_RANGE, 0, 0, 0, '0);
    add_op(OP_READ, 1, 0, 0, '0);
    add_op(OP_RANGE, 0, 0, 1, '0);
    add_op(OP_SET, 0, 0, 0, '0);
    // grown again: nodes above the short length kept stale sums
    add_length(1024);
    add_op(OP_RANGE, 0, 0, 1023, '0);
    add_op(OP_RANGE, 0, 1, 1023, '0);
    add_op(OP_ADD, 1, 0, 0, 32'h0000_0002);
    add_op(OP_RANGE, 0, 1, 1, '0);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 6)
        0: len = 1024;
        1: len = $urandom_range(1, 16);
        2: len = 2047;
        3: len = $urandom_range(1, 1024);
        4: len = 1;
        default: len = $urandom_range(1025, 2047);
      endcase
      add_length(len_t'(len));
      lim = (len > MAX_ELEMENTS) ? MAX_ELEMENTS : len;
      for (int i = 0; i < PHASE_ITEMS; i++) add_random_op(lim);
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (!timed_out && (stimulus.size() != 0 || start || cfg_valid ||
                          awaited_results.size() != 0))
      @(posedge clk);
    if (!timed_out) repeat (40) @(posedge clk);
    if (!timed_out && mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
